>>> design/blx_pkg.sv
// Package for the brace neutralizing lexer: item types, character codes and the byte lexing function.
package blx_pkg;

    // Character codes that the lexer recognises.
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Depth of the result queue in items.
    localparam int unsigned OBUF_DEPTH = 3;

    // Input item.
    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_text;
    } t_in;

    // Result item.
    typedef struct packed {
        logic [7:0] char_out;
        logic       last_out;
    } t_out;

    // Lexer modes, one-hot.
    typedef enum logic [4:0] {
        MODE_CODE  = 5'b00001,
        MODE_STR   = 5'b00010,
        MODE_CHR   = 5'b00100,
        MODE_LINE  = 5'b01000,
        MODE_BLOCK = 5'b10000
    } t_mode;

    // State that carries from one examined byte to the next.
    typedef struct packed {
        t_mode mode;
        logic  skip;
    } t_lex_state;

    // Outcome of examining one byte.
    typedef struct packed {
        t_lex_state st;
        logic [7:0] res;
    } t_lex_out;

    // Results that one accepted item pushes into the result queue.
    typedef struct packed {
        logic [1:0] count;
        t_out       first;
        t_out       second;
    } t_push;

    // Examine byte cur with lookahead nxt and return the byte to emit with the new state.
    function automatic t_lex_out lex_byte(t_lex_state st, logic [7:0] cur, logic [7:0] nxt);
        t_lex_out o;
        logic     closes;
        logic     blank_en;
        o        = '{st: st, res: cur};
        closes   = 1'b0;
        blank_en = 1'b0;
        if (st.skip) begin
            o.st.skip = 1'b0;
        end else begin
            case (st.mode)
                MODE_CODE: begin
                    if (cur == CH_DQUOTE) begin
                        o.st.mode = MODE_STR;
                    end else if (cur == CH_SQUOTE) begin
                        o.st.mode = MODE_CHR;
                    end else if (cur == CH_SLASH && nxt == CH_SLASH) begin
                        o.st.mode = MODE_LINE;
                    end else if (cur == CH_SLASH && nxt == CH_STAR) begin
                        o.st.mode = MODE_BLOCK;
                    end
                end
                MODE_STR: begin
                    if (cur == CH_BSLASH) begin
                        o.st.skip = 1'b1;
                    end else begin
                        closes   = (cur == CH_DQUOTE);
                        blank_en = 1'b1;
                    end
                end
                MODE_CHR: begin
                    if (cur == CH_BSLASH) begin
                        o.st.skip = 1'b1;
                    end else begin
                        closes   = (cur == CH_SQUOTE);
                        blank_en = 1'b1;
                    end
                end
                MODE_LINE: begin
                    closes   = (cur == CH_NL);
                    blank_en = 1'b1;
                end
                MODE_BLOCK: begin
                    // The slash that ends the comment is passed on unexamined.
                    if (cur == CH_STAR && nxt == CH_SLASH) begin
                        closes    = 1'b1;
                        o.st.skip = 1'b1;
                    end
                    blank_en = 1'b1;
                end
                default: begin
                    o.st.mode = MODE_CODE;
                end
            endcase
            if (closes) begin
                o.st.mode = MODE_CODE;
            end else if (blank_en && (cur inside {CH_LBRACE, CH_RBRACE})) begin
                o.res = CH_SPACE;
            end
        end
        return o;
    endfunction

endpackage

>>> design/brace_neutralizing_lexer_unit.sv
// Top level of the brace neutralizing lexer: lexer stage followed by the result queue.
//
//  Channel   Valid    Stall    Payload   Item
//  input     i_valid  o_stall  i_data    one source byte with its end flag
//  result    o_valid  i_stall  o_data    one output byte with its last flag
//
// One item is accepted per cycle while o_stall is low; its results are written to the queue.
// A byte comes out one item late, and the final item of a text of two or more bytes
// yields two results, which the result queue hands out one after the other.
// o_stall rises only when the three-entry result queue holds two or more items.
// Reset is synchronous and active low; it clears the lexer mode and the queue.
module brace_neutralizing_lexer_unit
    import blx_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    logic  accept;
    t_push push;
    logic  full;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    // Lexer stage.
    blx_lexer u_lexer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (i_data),
        .o_push   (push)
    );

    // Result queue.
    blx_obuf u_obuf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (accept),
        .i_push    (push),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .o_full    (full)
    );

endmodule

>>> design/blx_lexer.sv
// Lexer stage: mode and lookahead registers and the logic that turns one item into its results.
module blx_lexer
    import blx_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  t_in   i_data,
    output t_push o_push
);

    t_lex_state r_st;
    t_lex_state n_st;
    logic [7:0] r_held;
    logic [7:0] n_held;
    logic       r_held_valid;
    logic       n_held_valid;

    t_lex_state st_mid;
    t_lex_out   lex_held;
    t_lex_out   lex_last;

    // Examine the held byte first, then the final byte against a zero lookahead.
    always_comb begin
        lex_held = lex_byte(r_st, r_held, i_data.char_in);
        st_mid   = r_held_valid ? lex_held.st : r_st;
        lex_last = lex_byte(st_mid, i_data.char_in, CH_NUL);
    end

    // Results pushed and next state for an accepted item.
    always_comb begin
        o_push.count  = {1'b0, r_held_valid} + {1'b0, i_data.end_of_text};
        o_push.first  = '{char_out: lex_held.res, last_out: 1'b0};
        o_push.second = '{char_out: lex_last.res, last_out: 1'b1};
        if (!r_held_valid) begin
            o_push.first = o_push.second;
        end
        n_st         = r_st;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        if (i_accept) begin
            if (i_data.end_of_text) begin
                // The text ends here: everything returns to its reset values.
                n_st         = '{mode: MODE_CODE, skip: 1'b0};
                n_held_valid = 1'b0;
            end else begin
                n_st         = st_mid;
                n_held       = i_data.char_in;
                n_held_valid = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st         <= '{mode: MODE_CODE, skip: 1'b0};
            r_held_valid <= 1'b0;
        end else begin
            r_st         <= n_st;
            r_held_valid <= n_held_valid;
        end
    end

    // Lookahead byte, read only while it is marked valid.
    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

endmodule

>>> design/blx_obuf.sv
// Result queue: a shifting queue taking up to two items a cycle and giving one if unstalled.
module blx_obuf
    import blx_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_en,
    input  t_push i_push,
    input  logic  i_stall,
    output logic  o_valid,
    output t_out  o_data,
    output logic  o_full
);

    t_out       r_slot [OBUF_DEPTH];
    t_out       n_slot [OBUF_DEPTH];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       pop;
    logic [1:0] base;
    logic [1:0] push_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot[0];
    // Room for two more items is kept so that a new item never waits on the output side.
    assign o_full  = (r_cnt > 2'd1);
    assign pop     = o_valid && !i_stall;
    assign base    = r_cnt - {1'b0, pop};

    // Shift on a pop, then write the new items behind what remains.
    always_comb begin
        push_cnt = i_push_en ? i_push.count : 2'd0;
        for (int i = 0; i < OBUF_DEPTH; i++) begin
            if (pop && i < OBUF_DEPTH - 1) begin
                n_slot[i] = r_slot[i + 1];
            end else begin
                n_slot[i] = r_slot[i];
            end
            if (push_cnt != 2'd0 && base == 2'(i)) begin
                n_slot[i] = i_push.first;
            end
            if (push_cnt == 2'd2 && base + 2'd1 == 2'(i)) begin
                n_slot[i] = i_push.second;
            end
        end
        n_cnt = base + push_cnt;
    end

    // Fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Queue payload.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < OBUF_DEPTH; i++) begin
            r_slot[i] <= n_slot[i];
        end
    end

endmodule

>>> design/blx_checker.sv
// Port checker for the brace neutralizing lexer and its bind to the top level.
module blx_checker
    import blx_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input t_in  i_data,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);

    // A waiting result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result item withdrawn while stalled");

    // A waiting result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_data))
        else $error("result item changed while stalled");

    // The input side only stalls while results are queued.
    a_stall_needs_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with an empty result queue");

    // The final item of a text always leaves a result behind.
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_data.end_of_text |=> o_valid)
        else $error("final item produced no result");

endmodule

bind brace_neutralizing_lexer_unit blx_checker u_blx_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

>>> tb/brace_neutralizing_lexer_unit_tb.sv
// Self-checking testbench for the brace neutralizing lexer with a byte-level predictor.
`timescale 1ns / 1ps

module brace_neutralizing_lexer_unit_tb;
    import blx_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    logic i_stall;
    t_out o_data;

    brace_neutralizing_lexer_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // Source bytes waiting to be offered, and output bytes expected from the block.
    t_in  text_q[$];
    t_out blanked_q[$];

    // Predictor state: lexer mode, lookahead byte and skip flag for the next unexamined byte.
    t_mode      lx_mode     = MODE_CODE;
    logic [7:0] lx_held     = CH_NUL;
    logic       lx_held_vld = 1'b0;
    logic       lx_skip     = 1'b0;

    int unsigned n_acc      = 0;
    int unsigned n_err      = 0;
    int unsigned tx_idle    = 13;
    int unsigned rx_idle    = 58;
    int unsigned hold_cnt   = 0;
    logic        hold_done  = 1'b0;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Examine one byte against its lookahead and return the byte to emit.
    task automatic lex_examine(input logic [7:0] cur, input logic [7:0] nxt,
                               output logic [7:0] res);
        logic ends;
        res  = cur;
        ends = 1'b0;
        if (lx_skip) begin
            lx_skip = 1'b0;
        end else if (lx_mode == MODE_CODE) begin
            if (cur == CH_DQUOTE) begin
                lx_mode = MODE_STR;
            end else if (cur == CH_SQUOTE) begin
                lx_mode = MODE_CHR;
            end else if (cur == CH_SLASH && nxt == CH_SLASH) begin
                lx_mode = MODE_LINE;
            end else if (cur == CH_SLASH && nxt == CH_STAR) begin
                lx_mode = MODE_BLOCK;
            end
        end else if ((lx_mode == MODE_STR || lx_mode == MODE_CHR) && cur == CH_BSLASH) begin
            lx_skip = 1'b1;
        end else begin
            case (lx_mode)
                MODE_STR:  ends = (cur == CH_DQUOTE);
                MODE_CHR:  ends = (cur == CH_SQUOTE);
                MODE_LINE: ends = (cur == CH_NL);
                MODE_BLOCK: begin
                    // The closing slash is let through without a look.
                    if (cur == CH_STAR && nxt == CH_SLASH) begin
                        ends    = 1'b1;
                        lx_skip = 1'b1;
                    end
                end
                default: ;
            endcase
            if (ends) begin
                lx_mode = MODE_CODE;
            end else if (cur == CH_LBRACE || cur == CH_RBRACE) begin
                res = CH_SPACE;
            end
        end
    endtask

    // Work out the output bytes that one accepted item causes.
    task automatic predict_item(input t_in it);
        t_out r;
        if (lx_held_vld) begin
            lex_examine(lx_held, it.char_in, r.char_out);
            r.last_out = 1'b0;
            blanked_q.insert(blanked_q.size(), r);
        end
        if (it.end_of_text) begin
            lex_examine(it.char_in, CH_NUL, r.char_out);
            r.last_out = 1'b1;
            blanked_q.insert(blanked_q.size(), r);
            lx_mode     = MODE_CODE;
            lx_held     = CH_NUL;
            lx_held_vld = 1'b0;
            lx_skip     = 1'b0;
        end else begin
            lx_held     = it.char_in;
            lx_held_vld = 1'b1;
        end
    endtask

    task automatic add_byte(input logic [7:0] b, input logic eot);
        t_in it;
        it.char_in     = b;
        it.end_of_text = eot;
        text_q.insert(text_q.size(), it);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            add_byte(s[i], i == s.len() - 1);
        end
    endtask

    // Bytes drawn mostly from the characters that steer the lexer.
    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(0, 13))
            0:       b = CH_LBRACE;
            1:       b = CH_RBRACE;
            2:       b = CH_DQUOTE;
            3:       b = CH_SQUOTE;
            4:       b = CH_BSLASH;
            5, 6:    b = CH_SLASH;
            7:       b = CH_STAR;
            8:       b = CH_NL;
            9:       b = CH_SPACE;
            10:      b = CH_NUL;
            11, 12:  b = 8'($urandom_range(8'h61, 8'h7A));
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    // Idling mix moves on as items are accepted: sender light, then receiver light, then none.
    always @(posedge i_clk) begin
        if (n_acc < 160) begin
            tx_idle <= 13;
            rx_idle <= 58;
        end else if (n_acc < 320) begin
            tx_idle <= 58;
            rx_idle <= 13;
        end else begin
            tx_idle <= 0;
            rx_idle <= 0;
        end
    end

    // Long receiver hold-off once the stream runs without gaps, so the block backs up.
    always @(posedge i_clk) begin
        if (!hold_done && n_acc >= 360) begin
            hold_cnt  <= 48;
            hold_done <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Driver: offers queued items and predicts each one as it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_data  <= '0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_item(i_data);
                n_acc <= n_acc + 1;
            end
            if (!i_valid || !o_stall) begin
                if (text_q.size() != 0 && $urandom_range(0, 99) >= tx_idle) begin
                    i_valid <= 1'b1;
                    i_data  <= text_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each accepted output byte with the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (blanked_q.size() == 0) begin
                    if (n_err < 10) begin
                        $display("Unexpected item: char_out=%h last_out=%b",
                                 o_data.char_out, o_data.last_out);
                    end
                    n_err++;
                end else begin
                    t_out want;
                    want = blanked_q.pop_front();
                    if (o_data.char_out !== want.char_out || o_data.last_out !== want.last_out) begin
                        if (n_err < 10) begin
                            $display("Mismatch: char_out exp %h got %h, last_out exp %b got %b",
                                     want.char_out, o_data.char_out,
                                     want.last_out, o_data.last_out);
                        end
                        n_err++;
                    end
                end
            end
            i_stall <= (hold_cnt != 0) || ($urandom_range(0, 99) < rx_idle);
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int unsigned n_rand;
        int unsigned len;
        logic        noise;
        i_rst_n = 1'b0;

        // A one-byte text with every bit set.
        add_byte(8'hFF, 1'b1);
        // Braces in code and in a string, with an escaped quote inside it.
        add_text("{\"{\\\"}\"}");
        // Brace in a char literal, then a line comment closed by a newline.
        add_text("'}'//{\n");
        // Slash star slash already closes the comment, so the brace is code.
        add_text("/*/{");
        // A backslash left pending at the final byte.
        add_text("'\\");
        // A zero byte inside a block comment ahead of a brace.
        add_byte(CH_SLASH, 1'b0);
        add_byte(CH_STAR, 1'b0);
        add_byte(CH_NUL, 1'b0);
        add_byte(CH_LBRACE, 1'b1);

        // Random texts: mostly lexer-relevant characters, some pure noise.
        n_rand = 0;
        while (n_rand < 450) begin
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
            noise = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < len; i++) begin
                add_byte(noise ? 8'($urandom_range(0, 255)) : pick_byte(), i == len - 1);
                n_rand++;
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (text_q.size() != 0 || i_valid) @(negedge i_clk);
        while (blanked_q.size() != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);

        if (n_err == 0) begin
            $display("PASS brace_neutralizing_lexer_unit");
        end else begin
            $display("FAIL brace_neutralizing_lexer_unit");
        end
        $finish;
    end

    // Watchdog for a run that hangs.
    initial begin
        #3000000;
        $display("FAIL brace_neutralizing_lexer_unit");
        $finish;
    end

endmodule

>>> files.f
design/blx_pkg.sv
design/blx_lexer.sv
design/blx_obuf.sv
design/brace_neutralizing_lexer_unit.sv
design/blx_checker.sv
tb/brace_neutralizing_lexer_unit_tb.sv
